### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every clock edge out of reset
`define CHK_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/slir_pkg.sv
package slir_pkg;

  localparam int VAL_W = 32;
  localparam int CNT_W = 5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic                    action;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic             is_full;
  } out_t;

  typedef struct packed {
    logic eval;
    logic action;
    logic do_ins;
    logic do_rem;
  } cell_ctl_t;

endpackage

### rtl/slir_cell.sv
module slir_cell (
  input  logic                             clk,
  input  slir_pkg::cell_ctl_t              ctl,
  input  logic signed [slir_pkg::VAL_W-1:0] key,
  input  logic                             occ,
  input  logic                             left_sh,
  input  logic signed [slir_pkg::VAL_W-1:0] left_val,
  input  logic signed [slir_pkg::VAL_W-1:0] right_val,
  output logic                             sh,
  output logic                             hit,
  output logic signed [slir_pkg::VAL_W-1:0] val
);
  import slir_pkg::*;

  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    sh_r, sh_nxt;
  logic                    hit_r, hit_nxt;

  always_comb begin
    sh_nxt  = sh_r;
    hit_nxt = hit_r;
    val_nxt = val_r;
    if (ctl.eval) begin
      // cell sits at or past the insert / remove position
      if (ctl.action == ACT_REMOVE) begin
        sh_nxt = !occ || (val_r >= key);
      end else begin
        sh_nxt = !occ || (val_r > key);
      end
      hit_nxt = occ && (val_r == key);
    end
    if (ctl.do_ins && sh_r) begin
      val_nxt = left_sh ? left_val : key;
    end else if (ctl.do_rem && sh_r) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    hit_r <= hit_nxt;
    val_r <= val_nxt;
  end

  assign sh  = sh_r;
  assign hit = hit_r;
  assign val = val_r;

endmodule

### rtl/sorted_list_insert_remove.sv
// Sorted list of up to DEPTH signed 32-bit values held in a row of cells, one
// value per cell. Insert places the value after any equal entries and shifts
// larger ones up; it fails when the list is full. Remove takes out the first
// equal entry and shifts later ones down; it fails when the value is absent.
// Each beat gives one result with ok, count (modulo 32), is_empty and is_full.
// A beat is accepted only once the previous item has finished. An item goes
// through capture, a compare by every cell against it, an OR of the cell hit
// flags in groups of 16, and a shift of the row that registers the result. A
// new item is accepted while a finished result waits on the output; it then
// waits in the shift step, with the input stalled, until that result is taken.
module sorted_list_insert_remove #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  slir_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output slir_pkg::out_t out_data
);
  import slir_pkg::*;

  localparam int UW   = $clog2(DEPTH + 1);
  localparam int GRP  = 16;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_REDUCE, S_APPLY} state_t;

  state_t                  state_r;
  logic [UW-1:0]           used_r;
  logic                    out_valid_r;
  out_t                    out_r;
  logic                    act_r;
  logic signed [VAL_W-1:0] key_r;
  logic [NGRP-1:0]         grp_r;

  logic [DEPTH-1:0]            occ;
  logic [DEPTH-1:0]            sh;
  logic [DEPTH-1:0]            hit;
  logic signed [VAL_W-1:0]     val [DEPTH];
  logic [NGRP*GRP-1:0]         hit_pad;
  logic                        full, found, ins_ok, rem_ok, commit;
  logic [UW-1:0]               used_nxt;
  cell_ctl_t                   ctl;

  assign full   = (used_r == UW'(DEPTH));
  assign found  = |grp_r;
  assign ins_ok = (act_r == ACT_INSERT) && !full;
  assign rem_ok = (act_r == ACT_REMOVE) && found;
  assign commit = (state_r == S_APPLY) && (!out_valid_r || !out_stall);

  always_comb begin
    if (ins_ok) begin
      used_nxt = used_r + UW'(1);
    end else if (rem_ok) begin
      used_nxt = used_r - UW'(1);
    end else begin
      used_nxt = used_r;
    end
  end

  assign ctl.eval   = (state_r == S_EVAL);
  assign ctl.action = act_r;
  assign ctl.do_ins = commit && ins_ok;
  assign ctl.do_rem = commit && rem_ok;

  assign hit_pad = (NGRP*GRP)'(hit);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                    lsh;
    logic signed [VAL_W-1:0] lval, rval;
    assign occ[g] = (UW'(g) < used_r);
    if (g == 0) begin : g_first
      assign lsh  = 1'b0;
      assign lval = key_r;
    end else begin : g_mid
      assign lsh  = sh[g-1];
      assign lval = val[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rval = key_r;
    end else begin : g_inner
      assign rval = val[g+1];
    end
    slir_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (key_r),
      .occ       (occ[g]),
      .left_sh   (lsh),
      .left_val  (lval),
      .right_val (rval),
      .sh        (sh[g]),
      .hit       (hit[g]),
      .val       (val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r   <= in_data.action;
            key_r   <= in_data.value;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_r <= S_REDUCE;
        end
        S_REDUCE: begin
          for (int j = 0; j < NGRP; j++) begin
            grp_r[j] <= |hit_pad[j*GRP +: GRP];
          end
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (commit) begin
            used_r         <= used_nxt;
            out_r.ok       <= ins_ok || rem_ok;
            out_r.count    <= CNT_W'(used_nxt);
            out_r.is_empty <= (used_nxt == '0);
            out_r.is_full  <= (used_nxt == UW'(DEPTH));
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "assert_macros.svh"

  `CHK_ALWAYS(a_used_range, used_r <= UW'(DEPTH), "entry count beyond depth")
  `CHK_IMPLY(a_out_count, out_valid_r, out_r.count == CNT_W'(used_r), "result count stale")
  `CHK_NEXT(a_accept_eval, in_valid && !in_stall, state_r == S_EVAL, "beat not evaluated")
  `CHK_IMPLY(a_commit_ok, commit && (act_r == ACT_INSERT) && full, !ins_ok, "insert when full")

endmodule

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slir_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_PER_PHASE = 283;
  localparam int HOLD_AT = 640;
  localparam int HOLD_LEN = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  class list_scoreboard;
    logic signed [VAL_W-1:0] held[$];
    out_t awaited[$];
    int errors = 0;
    int n_results = 0;
    int n_ok = 0;
    int n_full = 0;
    int n_empty = 0;

    function void note_input(in_t it);
      out_t want;
      logic signed [VAL_W-1:0] v;
      int pos;
      v = it.value;
      want = '0;
      if (it.action == ACT_INSERT) begin
        if (held.size() < DEPTH) begin
          pos = 0;
          while (pos < held.size() && held[pos] <= v) pos++;
          held.insert(pos, v);
          want.ok = 1'b1;
        end
      end else if (held.size() != 0 && v >= held[0] && v <= held[held.size()-1]) begin
        pos = 0;
        while (pos < held.size() && held[pos] < v) pos++;
        if (pos < held.size() && held[pos] == v) begin
          held.delete(pos);
          want.ok = 1'b1;
        end
      end
      want.count = CNT_W'(held.size());
      want.is_empty = (held.size() == 0);
      want.is_full = (held.size() >= DEPTH);
      awaited.push_back(want);
    endfunction

    function void check_result(out_t got);
      out_t want;
      n_results++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result beat: ok=%0b count=%0d empty=%0b full=%0b",
                   got.ok, got.count, got.is_empty, got.is_full);
        return;
      end
      want = awaited.pop_front();
      if (want.ok) n_ok++;
      if (want.is_full) n_full++;
      if (want.is_empty) n_empty++;
      if (got.ok !== want.ok || got.count !== want.count ||
          got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch on result %0d: expected ok=%0b count=%0d empty=%0b full=%0b",
                   n_results, want.ok, want.count, want.is_empty, want.is_full);
          $display("  got ok=%0b count=%0d empty=%0b full=%0b",
                   got.ok, got.count, got.is_empty, got.is_full);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  list_scoreboard board = new();
  int send_pct = 0;
  int stall_pct = 0;
  int n_sent = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int cycles = 0;

  sorted_list_insert_remove #(.DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               board.awaited.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver, with one long hold-off once the run is well under way
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left = HOLD_LEN;
      hold_done = 1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  function automatic in_t mk(logic act, logic signed [VAL_W-1:0] v);
    in_t it;
    it.action = act;
    it.value = v;
    return it;
  endfunction

  function automatic in_t random_item(int insert_pct);
    in_t it;
    int n;
    int r;
    n = board.held.size();
    it.action = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
    r = $urandom_range(99);
    if (r < 40) begin
      it.value = $urandom_range(16) - 8;
    end else if (r < 75 && n > 0) begin
      it.value = board.held[$urandom_range(n - 1)];
    end else if (r < 85) begin
      case ($urandom_range(5))
        0: it.value = 32'sh8000_0000;
        1: it.value = 32'sh7fff_ffff;
        2: it.value = 32'sh8000_0001;
        3: it.value = 32'sh7fff_fffe;
        4: it.value = 0;
        default: it.value = -1;
      endcase
    end else begin
      it.value = $urandom;
    end
    return it;
  endfunction

  task automatic send_item(in_t it);
    while (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
    n_sent++;
  endtask

  initial begin
    int k;
    int p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_pct = 32;
    stall_pct <= 69;

    // directed: empty, range checks, duplicates, extremes, full
    send_item(mk(ACT_REMOVE, 0));
    send_item(mk(ACT_INSERT, 5));
    send_item(mk(ACT_INSERT, 5));
    send_item(mk(ACT_INSERT, -3));
    send_item(mk(ACT_INSERT, 100));
    send_item(mk(ACT_REMOVE, -4));
    send_item(mk(ACT_REMOVE, 101));
    send_item(mk(ACT_REMOVE, 100));
    send_item(mk(ACT_REMOVE, 7));
    send_item(mk(ACT_REMOVE, 5));
    send_item(mk(ACT_INSERT, 32'sh8000_0000));
    send_item(mk(ACT_INSERT, 32'sh7fff_ffff));
    send_item(mk(ACT_INSERT, -1));
    send_item(mk(ACT_INSERT, 0));
    for (k = 0; k < 10; k++)
      send_item(mk(ACT_INSERT, (k % 2) ? 32'sh5555_5555 : 32'shAAAA_AAAA + k));
    send_item(mk(ACT_INSERT, 1));
    send_item(mk(ACT_REMOVE, 32'sh7fff_ffff));
    send_item(mk(ACT_REMOVE, 32'sh8000_0000));

    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_pct = 32;
          stall_pct <= 69;
        end
        1: begin
          send_pct = 69;
          stall_pct <= 32;
        end
        default: begin
          send_pct = 0;
          stall_pct <= 0;
        end
      endcase
      // swing between filling and draining so full and empty both come up
      for (k = 0; k < RANDOM_PER_PHASE; k++)
        send_item(random_item(((k / 40) % 2) ? 25 : 75));
    end
    in_valid <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d operations sent, %0d results checked: %0d succeeded, %0d full, %0d empty",
             n_sent, board.n_results, board.n_ok, board.n_full, board.n_empty);
    $display("%0d mismatches, %0d results outstanding", board.errors, board.awaited.size());
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/slir_pkg.sv
rtl/slir_cell.sv
rtl/sorted_list_insert_remove.sv
sim/tb.sv
